>>> sv/frame_pacing_late_drop_monitor_macros.svh
// Assertion macros shared by the frame pacing lateness monitor RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef FRAME_PACING_LATE_DROP_MONITOR_MACROS_SVH
`define FRAME_PACING_LATE_DROP_MONITOR_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define FPLD_ASSERT_HOLDS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define FPLD_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define FPLD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/fpld_pkg.sv
// Shared types and constants for the frame pacing lateness monitor.
// No dependencies; imported by every module of the block.
package fpld_pkg;

  localparam int TIME_WIDTH = 48;
  localparam int SCALE_W    = 32;
  localparam int FRAC_W     = 16;
  localparam int PERIOD_W   = 20;
  localparam int COUNT_W    = 32;
  localparam int KIND_W     = 2;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_PRESENT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd2;

  // Register indexes (byte address bit 2)
  localparam logic REG_PTS_SCALE    = 1'b0;
  localparam logic REG_FRAME_PERIOD = 1'b1;

  localparam logic [SCALE_W-1:0]  PTS_SCALE_RESET    = 32'd65536;
  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RESET = 20'd16667;

  localparam logic signed [TIME_WIDTH-1:0] TIME_MAX = {1'b0, {(TIME_WIDTH-1){1'b1}}};
  localparam logic signed [TIME_WIDTH-1:0] TIME_MIN = {1'b1, {(TIME_WIDTH-1){1'b0}}};
  localparam logic [TIME_WIDTH-1:0]        SUM_MAX  = {TIME_WIDTH{1'b1}};
  localparam logic [COUNT_W-1:0]           COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [SCALE_W-1:0]  pts_scale_q16;
    logic [PERIOD_W-1:0] frame_period_us;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0]             kind;
    logic signed [TIME_WIDTH-1:0]  pts;
    logic [TIME_WIDTH-1:0]         now_us;
  } in_item_t;

  // Classified and scaled item handed from the front to the back
  typedef struct packed {
    logic [KIND_W-1:0]             kind;
    logic signed [TIME_WIDTH-1:0]  pts_us;
    logic [TIME_WIDTH-1:0]         now_us;
  } scaled_item_t;

  typedef struct packed {
    logic                          is_late;
    logic                          drop;
    logic signed [TIME_WIDTH-1:0]  error_us;
    logic signed [TIME_WIDTH-1:0]  pts_time_us;
    logic [TIME_WIDTH-1:0]         elapsed_us;
    logic [COUNT_W-1:0]            late_total;
    logic [COUNT_W-1:0]            dropped_total;
    logic [TIME_WIDTH-1:0]         lateness_sum_us;
    logic [TIME_WIDTH-1:0]         lateness_max_us;
  } out_item_t;

endpackage

>>> sv/fpld_cfg.sv
// Configuration register file with an APB-style write/read port.
// Depends on fpld_pkg for the register indexes, reset values and cfg_t.
module fpld_cfg import fpld_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic wr_en;
  logic reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pts_scale_q16   <= PTS_SCALE_RESET;
      cfg.frame_period_us <= FRAME_PERIOD_RESET;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_PTS_SCALE:    cfg.pts_scale_q16   <= pwdata[SCALE_W-1:0];
        REG_FRAME_PERIOD: cfg.frame_period_us <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_PTS_SCALE:    prdata = DATA_W'(cfg.pts_scale_q16);
      REG_FRAME_PERIOD: prdata = DATA_W'(cfg.frame_period_us);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> sv/fpld_front.sv
// Front end: accepts items and scales pts to microseconds in two register stages.
// Depends on fpld_pkg; feeds scaled items into fpld_queue.
module fpld_front import fpld_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         item_valid,
  output logic         item_ready,
  input  in_item_t     item,
  output logic         push,
  output scaled_item_t push_item,
  input  logic         queue_full
);

  localparam int HI_W  = TIME_WIDTH - FRAC_W;
  localparam int LO_W  = FRAC_W + SCALE_W;
  localparam int PROD_W = HI_W + SCALE_W;
  localparam logic [LO_W-1:0] ROUND_HALF = LO_W'(1) << (FRAC_W - 1);

  logic                   adv;
  logic [TIME_WIDTH-1:0]  mag;

  // stage 1: magnitude split into integer and fraction parts
  logic                   s1_valid;
  logic [KIND_W-1:0]      s1_kind;
  logic                   s1_neg;
  logic [HI_W-1:0]        s1_hi;
  logic [FRAC_W-1:0]      s1_lo;
  logic [TIME_WIDTH-1:0]  s1_now;

  // stage 2: partial products
  logic                   s2_valid;
  logic [KIND_W-1:0]      s2_kind;
  logic                   s2_neg;
  logic [PROD_W-1:0]      s2_hi_prod;
  logic [SCALE_W-1:0]     s2_lo_rnd;
  logic [TIME_WIDTH-1:0]  s2_now;

  logic [LO_W-1:0]        lo_prod;
  logic [LO_W-1:0]        lo_sum;
  logic [PROD_W-1:0]      q_sum;
  logic                   q_over;
  logic [TIME_WIDTH-1:0]  q_mag;
  logic [TIME_WIDTH-1:0]  q_neg;

  // advance the whole front when the last stage is empty or the queue has room
  assign adv        = !s2_valid || !queue_full;
  assign item_ready = adv;
  assign push       = s2_valid && !queue_full;

  assign mag = item.pts[TIME_WIDTH-1] ? (~$unsigned(item.pts)) + TIME_WIDTH'(1)
                                      : $unsigned(item.pts);

  assign lo_prod = {{SCALE_W{1'b0}}, s1_lo} * {{FRAC_W{1'b0}}, cfg.pts_scale_q16};
  assign lo_sum  = lo_prod + ROUND_HALF;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= item_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind    <= item.kind;
      s1_neg     <= item.pts[TIME_WIDTH-1];
      s1_hi      <= mag[TIME_WIDTH-1:FRAC_W];
      s1_lo      <= mag[FRAC_W-1:0];
      s1_now     <= item.now_us;
      s2_kind    <= s1_kind;
      s2_neg     <= s1_neg;
      s2_hi_prod <= {{SCALE_W{1'b0}}, s1_hi} * {{HI_W{1'b0}}, cfg.pts_scale_q16};
      s2_lo_rnd  <= lo_sum[LO_W-1:FRAC_W];
      s2_now     <= s1_now;
    end
  end

  // combine products, restore sign, saturate to the signed time range
  assign q_sum  = s2_hi_prod + PROD_W'(s2_lo_rnd);
  assign q_over = |q_sum[PROD_W-1:TIME_WIDTH-1];
  assign q_mag  = q_sum[TIME_WIDTH-1:0];
  assign q_neg  = (~q_mag) + TIME_WIDTH'(1);

  always_comb begin
    push_item.kind   = s2_kind;
    push_item.now_us = s2_now;
    if (q_over) begin
      push_item.pts_us = s2_neg ? TIME_MIN : TIME_MAX;
    end else begin
      push_item.pts_us = s2_neg ? $signed(q_neg) : $signed(q_mag);
    end
  end

endmodule

>>> sv/fpld_queue.sv
// Short FIFO between the front and back ends of the monitor.
// Depends on fpld_pkg for scaled_item_t and on the assertion macro header.
`include "frame_pacing_late_drop_monitor_macros.svh"
module fpld_queue import fpld_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  scaled_item_t push_item,
  output logic         full,
  input  logic         pop,
  output scaled_item_t pop_item,
  output logic         empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_PTR   = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  scaled_item_t      entries [DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  assign full     = (count == FULL_COUNT);
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_comb begin
    case ({push, pop})
      2'b10:   count_next = count + CW'(1);
      2'b01:   count_next = count - CW'(1);
      default: count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  `FPLD_ASSERT_IMPLIES(a_no_push_when_full, clk, rst, push, !full, "push into full queue")
  `FPLD_ASSERT_IMPLIES(a_no_pop_when_empty, clk, rst, pop, !empty, "pop from empty queue")
  `FPLD_ASSERT_IMPLIES(a_ptrs_meet, clk, rst, empty || full, wr_ptr == rd_ptr, "pointers out of step")

endmodule

>>> sv/fpld_back.sv
// Back end: start tracking, timing error, late/drop tests and saturating statistics.
// Depends on fpld_pkg and the assertion macro header; drains fpld_queue.
`include "frame_pacing_late_drop_monitor_macros.svh"
module fpld_back import fpld_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         q_empty,
  input  scaled_item_t q_item,
  output logic         pop,
  output logic         result_valid,
  input  logic         result_ready,
  output out_item_t    result
);

  function automatic logic signed [TIME_WIDTH-1:0] sat_sub(
    input logic signed [TIME_WIDTH-1:0] a,
    input logic signed [TIME_WIDTH-1:0] b
  );
    logic signed [TIME_WIDTH:0] d;
    d = {a[TIME_WIDTH-1], a} - {b[TIME_WIDTH-1], b};
    if (d[TIME_WIDTH] != d[TIME_WIDTH-1]) begin
      return d[TIME_WIDTH] ? TIME_MIN : TIME_MAX;
    end
    return d[TIME_WIDTH-1:0];
  endfunction

  logic adv;

  // start tracking state
  logic                          started;
  logic [TIME_WIDTH-1:0]         start_wall;
  logic signed [TIME_WIDTH-1:0]  start_pts;

  // kind decode of the queue head
  logic is_present;
  logic is_dropchk;
  logic is_restart;
  logic latch;
  logic [TIME_WIDTH-1:0]         eff_wall;
  logic signed [TIME_WIDTH-1:0]  eff_pts;

  // stage A: elapsed and target
  logic                          a_valid;
  logic                          a_present;
  logic                          a_dropchk;
  logic                          a_active;
  logic signed [TIME_WIDTH-1:0]  a_pts_us;
  logic [TIME_WIDTH-1:0]         a_elapsed;
  logic signed [TIME_WIDTH-1:0]  a_target;

  // stage B: timing error
  logic                          b_valid;
  logic                          b_late_chk;
  logic                          b_drop_chk;
  logic signed [TIME_WIDTH-1:0]  b_err;
  logic signed [TIME_WIDTH-1:0]  b_pts_us;
  logic [TIME_WIDTH-1:0]         b_elapsed;
  logic signed [TIME_WIDTH-1:0]  el_clamped;

  // statistics
  logic [COUNT_W-1:0]            late_count;
  logic [COUNT_W-1:0]            late_count_next;
  logic [COUNT_W-1:0]            drop_count;
  logic [COUNT_W-1:0]            drop_count_next;
  logic [TIME_WIDTH-1:0]         lateness_sum;
  logic [TIME_WIDTH-1:0]         lateness_sum_next;
  logic [TIME_WIDTH-1:0]         lateness_max;
  logic [TIME_WIDTH-1:0]         lateness_max_next;

  logic signed [TIME_WIDTH-1:0]  half_period;
  logic signed [TIME_WIDTH-1:0]  twice_period;
  logic                          late;
  logic                          drop;
  logic [TIME_WIDTH-1:0]         lateness;
  logic [TIME_WIDTH:0]           sum_ext;

  // the whole back pipeline moves when the output register is free
  assign adv = !result_valid || result_ready;
  assign pop = adv && !q_empty;

  always_comb begin
    is_present = 1'b0;
    is_dropchk = 1'b0;
    is_restart = 1'b0;
    unique case (q_item.kind)
      KIND_PRESENT: is_present = 1'b1;
      KIND_DROP:    is_dropchk = 1'b1;
      KIND_RESTART: is_restart = 1'b1;
      default: ;
    endcase
  end

  // first present check after reset or a restart latches the start point
  assign latch    = is_present && !started;
  assign eff_wall = latch ? q_item.now_us : start_wall;
  assign eff_pts  = latch ? q_item.pts_us : start_pts;

  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (pop) begin
      if (is_restart) begin
        started <= 1'b0;
      end else if (latch) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && latch) begin
      start_wall <= q_item.now_us;
      start_pts  <= q_item.pts_us;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      a_valid      <= pop;
      b_valid      <= a_valid;
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_present <= is_present;
      a_dropchk <= is_dropchk;
      a_active  <= is_present || (is_dropchk && started);
      a_pts_us  <= (is_present || is_dropchk) ? q_item.pts_us : '0;
      a_elapsed <= q_item.now_us - eff_wall;
      a_target  <= sat_sub(q_item.pts_us, eff_pts);
    end
  end

  assign el_clamped = a_elapsed[TIME_WIDTH-1] ? TIME_MAX : $signed(a_elapsed);

  always_ff @(posedge clk) begin
    if (adv) begin
      b_late_chk <= a_present && a_active;
      b_drop_chk <= a_dropchk && a_active;
      b_err      <= a_active ? sat_sub(el_clamped, a_target) : '0;
      b_elapsed  <= a_active ? a_elapsed : '0;
      b_pts_us   <= a_pts_us;
    end
  end

  assign half_period  = $signed(TIME_WIDTH'(cfg.frame_period_us >> 1));
  assign twice_period = $signed(TIME_WIDTH'({cfg.frame_period_us, 1'b0}));
  assign late         = b_late_chk && (b_err > half_period);
  assign drop         = b_drop_chk && (b_err > twice_period);
  assign lateness     = $unsigned(b_err);
  assign sum_ext      = {1'b0, lateness_sum} + {1'b0, lateness};

  always_comb begin
    late_count_next   = late_count;
    drop_count_next   = drop_count;
    lateness_sum_next = lateness_sum;
    lateness_max_next = lateness_max;
    if (late) begin
      if (late_count != COUNT_MAX) begin
        late_count_next = late_count + COUNT_W'(1);
      end
      lateness_sum_next = sum_ext[TIME_WIDTH] ? SUM_MAX : sum_ext[TIME_WIDTH-1:0];
      if (lateness > lateness_max) begin
        lateness_max_next = lateness;
      end
    end
    if (drop && drop_count != COUNT_MAX) begin
      drop_count_next = drop_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      late_count   <= '0;
      drop_count   <= '0;
      lateness_sum <= '0;
      lateness_max <= '0;
    end else if (adv && b_valid) begin
      late_count   <= late_count_next;
      drop_count   <= drop_count_next;
      lateness_sum <= lateness_sum_next;
      lateness_max <= lateness_max_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.is_late         <= late;
      result.drop            <= drop;
      result.error_us        <= b_err;
      result.pts_time_us     <= b_pts_us;
      result.elapsed_us      <= b_elapsed;
      result.late_total      <= late_count_next;
      result.dropped_total   <= drop_count_next;
      result.lateness_sum_us <= lateness_sum_next;
      result.lateness_max_us <= lateness_max_next;
    end
  end

  `FPLD_ASSERT_IMPLIES(a_late_xor_drop, clk, rst, result_valid, !(result.is_late && result.drop), "late and drop on one beat")
  `FPLD_ASSERT_HOLDS(a_max_within_sum, clk, rst, lateness_max <= lateness_sum, "lateness max above sum")
  `FPLD_ASSERT_NEXT(a_late_count_grows, clk, rst, 1'b1, late_count >= $past(late_count), "late count went down")
  `FPLD_ASSERT_NEXT(a_restart_clears, clk, rst, pop && is_restart, !started, "restart left start set")

endmodule

>>> sv/frame_pacing_late_drop_monitor.sv
// Frame pacing lateness monitor: top level tying config, front, queue and back.
// Depends on fpld_pkg, fpld_cfg, fpld_front, fpld_queue and fpld_back.
//
// Usage:
//   item channel (item_valid/item_ready/item): one beat per frame event, kind
//   present check, stale drop check or restart, with pts and wall time.
//   result channel (result_valid/result_ready/result): exactly one beat per item,
//   in order, carrying the late/drop flags, timing error and statistics.
//   APB port: register 0 (addr 0) is the Q16.16 pts scale, register 1 (addr 4)
//   the frame period in microseconds. Write only while no item is in flight.
// Timing: after the accepting edge the item passes the second scaling stage,
//   a queue slot, the elapsed and error stages and the output register before
//   result_valid rises. One item per cycle is sustained while result_ready is
//   high; the pts multiply and start-tracking loop run at one item per cycle.
// Reset clears the pipeline, the start flag and all statistics and loads the
//   register defaults (scale 1.0, period 16667 us).
// When result_ready is low the back end holds its result; the queue and the two
//   scaling stages absorb up to QUEUE_DEPTH + 2 more items before item_ready falls.
module frame_pacing_late_drop_monitor import fpld_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  in_item_t          item,
  output logic              result_valid,
  input  logic              result_ready,
  output out_item_t         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t         cfg;
  logic         push;
  scaled_item_t push_item;
  logic         q_full;
  logic         pop;
  scaled_item_t pop_item;
  logic         q_empty;

  fpld_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .push       (push),
    .push_item  (push_item),
    .queue_full (q_full)
  );

  fpld_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .empty     (q_empty)
  );

  fpld_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_empty      (q_empty),
    .q_item       (pop_item),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
